>>> hdl/vsc_pkg.sv
// ----------------------------------------------------------------------------
// Vigenere stream cipher package
// Shared types and constants for the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package vsc_pkg;

	localparam int ALPHA_LEN = 26;
	localparam logic [7:0] UPPER_A = 8'h41;
	localparam logic [7:0] UPPER_Z = 8'h5A;
	localparam logic [7:0] LOWER_A = 8'h61;
	localparam logic [7:0] LOWER_Z = 8'h7A;
	localparam logic [63:0] KEY_RESET_WORD = 64'h4141_4141_4141_4141;

	localparam int KEY_WORDS = 4;
	localparam int KEY_BYTES = KEY_WORDS * 8;
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes.
	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_KEY_LENGTH = 3'd1;
	localparam logic [2:0] REG_KEY_CHARS_0 = 3'd2;
	localparam logic [2:0] REG_KEY_CHARS_3 = 3'd5;

	// Cipher direction.
	localparam logic MODE_ENCRYPT = 1'b0;

	// One classified word as it travels from the front end to the back end.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       letter;
		logic       lower;
		logic [4:0] offset;
		logic [4:0] amount;
	} vsc_item_t;

endpackage

>>> hdl/vsc_front.sv
// ----------------------------------------------------------------------------
// Vigenere front end
// Holds the configuration and the key position, classifies each input word
// and looks up the shift that the back end must add.
// ----------------------------------------------------------------------------
module vsc_front import vsc_pkg::*; #(
	parameter int KEY_MAX = 32,
	parameter int POS_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [2:0]       cfg_index,
	input  logic [63:0]      cfg_data,
	input  logic             in_valid,
	input  logic [7:0]       in_byte,
	input  logic             message_end,
	input  logic             queue_full,
	output logic             push,
	output vsc_item_t        item
);

	logic                       mode_q;
	logic [5:0]                 key_length_q;
	logic [KEY_BYTES*8-1:0]     key_q;
	logic [POS_W-1:0]           key_position_q;

	logic [5:0]       len;
	logic [POS_W-1:0] pos_eff;
	logic [5:0]       pos_inc;
	logic [7:0]       bit_idx;
	logic [7:0]       kbyte;
	logic [4:0]       kshift;
	logic             c_upper;
	logic             c_lower;
	logic             c_letter;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENCRYPT;
			key_length_q <= 6'd1;
			key_q <= {KEY_WORDS{KEY_RESET_WORD}};
		end else if (cfg_valid) begin
			if (cfg_index == REG_MODE) begin
				mode_q <= cfg_data[0];
			end else if (cfg_index == REG_KEY_LENGTH) begin
				key_length_q <= cfg_data[5:0];
			end else if (cfg_index >= REG_KEY_CHARS_0 && cfg_index <= REG_KEY_CHARS_3) begin
				key_q[(32'(cfg_index - REG_KEY_CHARS_0))*64 +: 64] <= cfg_data;
			end
		end
	end

	always_comb begin
		if (key_length_q == 6'd0) begin
			len = 6'd1;
		end else if (key_length_q > 6'(KEY_MAX)) begin
			len = 6'(KEY_MAX);
		end else begin
			len = key_length_q;
		end
		// A position left beyond a shortened key starts over at letter 0.
		pos_eff = (6'(key_position_q) >= len) ? '0 : key_position_q;
		pos_inc = 6'(pos_eff) + 6'd1;
		bit_idx = {5'(pos_eff), 3'b000};
		kbyte = key_q[bit_idx +: 8];

		if (kbyte >= UPPER_A && kbyte <= UPPER_Z) begin
			kshift = 5'(kbyte - UPPER_A);
		end else if (kbyte >= LOWER_A && kbyte <= LOWER_Z) begin
			kshift = 5'(kbyte - LOWER_A);
		end else begin
			kshift = 5'd0;
		end

		c_upper = (in_byte >= UPPER_A) && (in_byte <= UPPER_Z);
		c_lower = (in_byte >= LOWER_A) && (in_byte <= LOWER_Z);
		c_letter = c_upper || c_lower;

		item.data = in_byte;
		item.last = message_end;
		item.letter = c_letter;
		item.lower = c_lower;
		item.offset = c_lower ? 5'(in_byte - LOWER_A) : 5'(in_byte - UPPER_A);
		if (mode_q == MODE_ENCRYPT || kshift == 5'd0) begin
			item.amount = kshift;
		end else begin
			item.amount = 5'(ALPHA_LEN) - kshift;
		end
	end

	assign push = in_valid && !queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_position_q <= '0;
		end else if (push) begin
			if (message_end) begin
				key_position_q <= '0;
			end else if (c_letter) begin
				key_position_q <= (pos_inc >= len) ? '0 : POS_W'(pos_inc);
			end else begin
				key_position_q <= pos_eff;
			end
		end
	end

endmodule

>>> hdl/vsc_queue.sv
// ----------------------------------------------------------------------------
// Vigenere item queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module vsc_queue import vsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  vsc_item_t push_item,
	input  logic      pop,
	output logic      full,
	output logic      empty,
	output vsc_item_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	vsc_item_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/vsc_back.sv
// ----------------------------------------------------------------------------
// Vigenere back end
// Applies the shift modulo 26 to letters; the output register holds results.
// ----------------------------------------------------------------------------
module vsc_back import vsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      queue_empty,
	input  vsc_item_t head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output logic [7:0] out_byte,
	output logic      out_last
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       load;
	logic [5:0] sum;
	logic [4:0] wrapped;
	logic [7:0] result;

	assign load = !out_valid_q || !out_stall;
	assign pop = load && !queue_empty;

	always_comb begin
		sum = 6'(head.offset) + 6'(head.amount);
		// Both operands are below 26, so one subtraction is enough.
		wrapped = (sum >= 6'(ALPHA_LEN)) ? 5'(sum - 6'(ALPHA_LEN)) : 5'(sum);
		if (head.letter) begin
			result = (head.lower ? LOWER_A : UPPER_A) + 8'(wrapped);
		end else begin
			result = head.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !queue_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_q <= result;
			out_last_q <= head.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

endmodule

>>> hdl/vigenere_stream_cipher.sv
// ----------------------------------------------------------------------------
// Vigenere stream cipher
// Shifts ASCII letters by a repeating key, one byte per clock unless stalled.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  cfg      cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[63:0]
//  in       in_valid / in_stall    in_byte[7:0], message_end
//  out      out_valid / out_stall  out_byte[7:0], out_last
//
// One byte is accepted per clock while in_stall is low; it enters the queue
// when accepted and moves to the output register when the back end pops it.
// The front end updates the key position when a byte is accepted: it steps
// on after a letter, holds after other bytes and returns to 0 at message_end.
// in_stall rises only when the two-entry queue is full, a state that
// can only be reached while out_stall holds the output register.
// Reset restores mode 0, key length 1, an all-'A' key and key position 0.
// cfg_ready is always high; writes take effect at once.
module vigenere_stream_cipher import vsc_pkg::*; #(
	parameter int KEY_MAX = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        message_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        out_last
);

	localparam int POS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

	vsc_item_t push_item;
	vsc_item_t head;
	logic      push;
	logic      pop;
	logic      full;
	logic      empty;

	assign cfg_ready = 1'b1;
	assign in_stall = full;

	vsc_front #(
		.KEY_MAX(KEY_MAX),
		.POS_W(POS_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_byte(in_byte),
		.message_end(message_end),
		.queue_full(full),
		.push(push),
		.item(push_item)
	);

	vsc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.full(full),
		.empty(empty),
		.head(head)
	);

	vsc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.queue_empty(empty),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.out_last(out_last)
	);

endmodule

>>> hdl/vsc_checker.sv
// ----------------------------------------------------------------------------
// Vigenere port checker
// Watches the top-level ports and tracks how many words are in flight.
// ----------------------------------------------------------------------------
module vsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       out_last
);

	logic [2:0] outstanding_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (in_acc && !out_acc) begin
			outstanding_q <= outstanding_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			outstanding_q <= outstanding_q - 1'b1;
		end
	end

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("output word changed while stalled");

	// Every result belongs to an accepted input word.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outstanding_q != 3'd0)
		else $error("result without a pending input word");

	// The queue and the output register hold at most three words.
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 3'd3)
		else $error("more words in flight than storage allows");

	// Input is only held off when the queue really holds a backlog.
	a_stall_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> outstanding_q >= 3'd2)
		else $error("input stalled without a backlog");

endmodule

bind vigenere_stream_cipher vsc_checker u_vsc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_byte(out_byte),
	.out_last(out_last)
);
